@@ rtl/evd_pkg.sv @@
package evd_pkg;

  localparam int ElemW   = 16;
  localparam int DotW    = 42;
  localparam int NormW   = 42;
  localparam int DiffW   = 44;
  localparam int DistW   = 23;
  localparam int SqInW   = 64;
  localparam int SqRootW = 32;
  localparam int SqRemW  = 35;
  localparam int RootW   = 31;
  localparam int DivW    = 2 * RootW;
  localparam int QW      = 18;
  localparam int SqSteps  = SqInW / 2;
  localparam int DivSteps = DotW + 36;
  localparam int CntW     = 7;

  localparam logic MODE_COSINE = 1'b0;
  localparam logic MODE_EUCLID = 1'b1;

  localparam logic [DistW-1:0] OneQ16 = DistW'(65536);

  typedef enum logic [3:0] {
    ST_ACC,
    ST_START,
    ST_SQA,
    ST_LDB,
    ST_SQB,
    ST_MUL,
    ST_DIVL,
    ST_DIV,
    ST_SQE,
    ST_DONE
  } evd_state_t;

  typedef enum logic [1:0] {
    SQ_TRACK,
    SQ_DET,
    SQ_DIFF
  } evd_sq_src_t;

  typedef enum logic [1:0] {
    RES_ONE,
    RES_EUC,
    RES_COS
  } evd_res_t;

  typedef struct packed {
    logic        acc_en;
    logic        clear;
    logic        sq_load;
    evd_sq_src_t sq_src;
    logic        sq_step;
    logic        ra_store;
    logic        rb_store;
    logic        mul_en;
    logic        div_load;
    logic        div_step;
    logic        res_load;
    evd_res_t    res_sel;
  } evd_cmd_t;

  typedef struct packed {
    logic euclid;
    logic norm_zero;
    logic out_busy;
  } evd_stat_t;

endpackage

@@ rtl/evd_ctrl.sv @@
module evd_ctrl import evd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_element,
  input  evd_stat_t stat,
  output logic      in_stall,
  output evd_cmd_t  cmd
);

  evd_state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic sq_last, div_last;

  assign sq_last  = (cnt_r == CntW'(SqSteps - 1));
  assign div_last = (cnt_r == CntW'(DivSteps - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CntW'(1);
    unique case (state_r)
      ST_ACC: begin
        cnt_nxt = '0;
        if (in_valid && in_last_element) state_nxt = ST_START;
      end
      ST_START: begin
        cnt_nxt = '0;
        if (stat.euclid == MODE_EUCLID) state_nxt = ST_SQE;
        else if (stat.norm_zero) state_nxt = ST_DONE;
        else state_nxt = ST_SQA;
      end
      ST_SQA: begin
        if (sq_last) begin
          state_nxt = ST_LDB;
          cnt_nxt   = '0;
        end
      end
      ST_LDB: begin
        state_nxt = ST_SQB;
        cnt_nxt   = '0;
      end
      ST_SQB: begin
        if (sq_last) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIVL;
        cnt_nxt   = '0;
      end
      ST_DIVL: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end
      end
      ST_SQE: begin
        if (sq_last) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end
      end
      ST_DONE: begin
        cnt_nxt = '0;
        if (!stat.out_busy) state_nxt = ST_ACC;
      end
      default: begin
        state_nxt = ST_ACC;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_ACC: begin
        in_stall   = 1'b0;
        cmd.acc_en = in_valid;
      end
      ST_START: begin
        cmd.sq_load = 1'b1;
        cmd.sq_src  = (stat.euclid == MODE_EUCLID) ? SQ_DIFF : SQ_TRACK;
      end
      ST_SQA: begin
        cmd.sq_step  = 1'b1;
        cmd.ra_store = sq_last;
      end
      ST_LDB: begin
        cmd.sq_load = 1'b1;
        cmd.sq_src  = SQ_DET;
      end
      ST_SQB: begin
        cmd.sq_step  = 1'b1;
        cmd.rb_store = sq_last;
      end
      ST_MUL:  cmd.mul_en   = 1'b1;
      ST_DIVL: cmd.div_load = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_SQE:  cmd.sq_step  = 1'b1;
      ST_DONE: begin
        if (stat.euclid == MODE_EUCLID) cmd.res_sel = RES_EUC;
        else if (stat.norm_zero) cmd.res_sel = RES_ONE;
        else cmd.res_sel = RES_COS;
        cmd.res_load = !stat.out_busy;
        cmd.clear    = !stat.out_busy;
      end
      default: cmd = '0;
    endcase
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_element) |=> in_stall)
    else $error("word accepted after last element");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> !in_stall)
    else $error("input not reopened after result");
`endif

endmodule

@@ rtl/evd_dp.sv @@
module evd_dp import evd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  evd_cmd_t                cmd,
  output evd_stat_t               stat,
  input  logic signed [ElemW-1:0] track_value,
  input  logic signed [ElemW-1:0] det_value,
  input  logic                    cfg_we,
  input  logic                    cfg_mode,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [DistW-1:0]        distance
);

  logic                       mode_r;
  logic signed [DotW-1:0]     dot_r, dot_nxt;
  logic [NormW-1:0]           tn_r, tn_nxt, dn_r, dn_nxt;
  logic [DiffW-1:0]           ds_r, ds_nxt;

  logic signed [2*ElemW-1:0]  prod_dot, prod_ta, prod_db;
  logic signed [ElemW:0]      diff;
  logic signed [2*ElemW+1:0]  prod_diff;
  logic signed [DotW:0]       dot_ext;
  logic [NormW:0]             tn_ext, dn_ext;
  logic [DiffW:0]             ds_ext;

  always_comb begin
    prod_dot  = track_value * det_value;
    prod_ta   = track_value * track_value;
    prod_db   = det_value * det_value;
    diff      = (ElemW+1)'(track_value) - (ElemW+1)'(det_value);
    prod_diff = diff * diff;
    dot_ext   = (DotW+1)'(dot_r) + (DotW+1)'(prod_dot);
    tn_ext    = (NormW+1)'(tn_r) + (NormW+1)'($unsigned(prod_ta));
    dn_ext    = (NormW+1)'(dn_r) + (NormW+1)'($unsigned(prod_db));
    ds_ext    = (DiffW+1)'(ds_r) + (DiffW+1)'($unsigned(prod_diff));
    if (dot_ext[DotW] != dot_ext[DotW-1])
      dot_nxt = dot_ext[DotW] ? {1'b1, {(DotW-1){1'b0}}} : {1'b0, {(DotW-1){1'b1}}};
    else
      dot_nxt = dot_ext[DotW-1:0];
    tn_nxt = tn_ext[NormW] ? '1 : tn_ext[NormW-1:0];
    dn_nxt = dn_ext[NormW] ? '1 : dn_ext[NormW-1:0];
    ds_nxt = ds_ext[DiffW] ? '1 : ds_ext[DiffW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COSINE;
      dot_r  <= '0;
      tn_r   <= '0;
      dn_r   <= '0;
      ds_r   <= '0;
    end else begin
      if (cfg_we) mode_r <= cfg_mode;
      if (cmd.clear) begin
        dot_r <= '0;
        tn_r  <= '0;
        dn_r  <= '0;
        ds_r  <= '0;
      end else if (cmd.acc_en) begin
        dot_r <= dot_nxt;
        tn_r  <= tn_nxt;
        dn_r  <= dn_nxt;
        ds_r  <= ds_nxt;
      end
    end
  end

  logic [SqInW-1:0]   sq_x_r, sq_x_load;
  logic [SqRemW-3:0]  sq_rem_r, sq_rem_nxt;
  logic [SqRootW-1:0] sq_root_r, sq_root_nxt;
  logic [SqRemW-1:0]  sq_rem_sh, sq_trial, sq_sub;
  logic               sq_ge;
  logic [RootW-1:0]   ra_r, rb_r;
  logic [DivW-1:0]    d_r;

  always_comb begin
    unique case (cmd.sq_src)
      SQ_TRACK: sq_x_load = {2'b00, tn_r, 20'b0};
      SQ_DET:   sq_x_load = {2'b00, dn_r, 20'b0};
      SQ_DIFF:  sq_x_load = {18'b0, ds_r, 2'b00};
      default:  sq_x_load = '0;
    endcase
    sq_rem_sh   = {sq_rem_r, sq_x_r[SqInW-1:SqInW-2]};
    sq_trial    = {1'b0, sq_root_r, 2'b01};
    sq_ge       = (sq_rem_sh >= sq_trial);
    sq_sub      = sq_rem_sh - sq_trial;
    sq_rem_nxt  = sq_ge ? sq_sub[SqRemW-3:0] : sq_rem_sh[SqRemW-3:0];
    sq_root_nxt = {sq_root_r[SqRootW-2:0], sq_ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sq_x_r    <= sq_x_load;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (cmd.sq_step) begin
      sq_x_r    <= {sq_x_r[SqInW-3:0], 2'b00};
      sq_rem_r  <= sq_rem_nxt;
      sq_root_r <= sq_root_nxt;
    end
    if (cmd.ra_store) ra_r <= sq_root_nxt[RootW-1:0];
    if (cmd.rb_store) rb_r <= sq_root_nxt[RootW-1:0];
    if (cmd.mul_en)   d_r  <= ra_r * rb_r;
  end

  logic [DotW-1:0]  mag_r, mag_load;
  logic [DivW-1:0]  r_r, r_nxt;
  logic [DivW:0]    r_sh, r_sub;
  logic             div_ge, neg_r;
  logic [QW-1:0]    q_r, q_nxt, q_fin;
  logic [DistW-1:0] cos_dist, res;

  always_comb begin
    mag_load = dot_r[DotW-1] ? $unsigned(-dot_r) : $unsigned(dot_r);
    r_sh     = {r_r, mag_r[DotW-1]};
    div_ge   = (r_sh >= {1'b0, d_r});
    r_sub    = r_sh - {1'b0, d_r};
    r_nxt    = div_ge ? r_sub[DivW-1:0] : r_sh[DivW-1:0];
    q_nxt    = q_r[QW-1] ? q_r : {q_r[QW-2:0], div_ge};
    q_fin    = q_r[QW-1] ? {1'b1, {(QW-1){1'b0}}} : q_r;
    if (neg_r) cos_dist = OneQ16 + DistW'(q_fin);
    else if (DistW'(q_fin) >= OneQ16) cos_dist = '0;
    else cos_dist = OneQ16 - DistW'(q_fin);
    unique case (cmd.res_sel)
      RES_ONE: res = OneQ16;
      RES_EUC: res = sq_root_r[DistW-1:0];
      RES_COS: res = cos_dist;
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      mag_r <= mag_load;
      neg_r <= dot_r[DotW-1];
      r_r   <= '0;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      mag_r <= {mag_r[DotW-2:0], 1'b0};
      r_r   <= r_nxt;
      q_r   <= q_nxt;
    end
  end

  logic             out_valid_r;
  logic [DistW-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.res_load) dist_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign distance       = dist_r;
  assign stat.euclid    = mode_r;
  assign stat.norm_zero = (tn_r == '0) || (dn_r == '0);
  assign stat.out_busy  = out_valid_r && out_stall;

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !(out_valid_r && out_stall))
    else $error("result overwrites a word still held");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (r_r < d_r))
    else $error("division remainder not below divisor");
`endif

endmodule

@@ rtl/embedding_vector_distance.sv @@
// Accepts one element pair per cycle while accumulating; in_stall is high in every other state.
// After the last element: the euclidean result comes from a 32-step square root; cosine uses
// two 32-step square roots, a multiply and a 78-step divider, and gives one if a norm is zero.
// A new vector pair is taken only after the previous result is loaded; one pair in work at a time.
// rst_n is synchronous, active low: clears accumulators, mode (cosine), controller and output valid.
module embedding_vector_distance import evd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ElemW-1:0] in_track_value,
  input  logic signed [ElemW-1:0] in_det_value,
  input  logic                    in_last_element,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DistW-1:0]        out_distance,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_metric_mode
);

  evd_cmd_t  cmd;
  evd_stat_t stat;

  assign cfg_ready = 1'b1;

  evd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .stat            (stat),
    .in_stall        (in_stall),
    .cmd             (cmd)
  );

  evd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .track_value (in_track_value),
    .det_value   (in_det_value),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_mode    (cfg_metric_mode),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .distance    (out_distance)
  );

endmodule
